>>> hdl/sgm_pkg.sv
// Shared constants, types and helpers for the Sobel gradient magnitude block.
package sgm_pkg;

   // Default line store depth (widest supported row)
   localparam int MAX_WIDTH_DEFAULT = 1024;

   // Field widths
   localparam int PIXEL_W      = 8;
   localparam int GRAD_W       = 11;
   localparam int ABS_W        = 8;
   localparam int MAG_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // Register reset values
   localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   // Smallest legal frame dimension
   localparam int MIN_DIM = 3;

   // Rounded magnitude: floor((2a + 6b + 5) / 10) via reciprocal multiply.
   // 3277 / 2^15 overshoots 1/10 by so little that the floor stays exact for
   // every numerator up to 2045.
   localparam int NUM_W        = 11;
   localparam int PROD_W       = 23;
   localparam int DIV10_SHIFT  = 15;
   localparam logic [PROD_W-1:0] DIV10_RECIP = 23'd3277;
   localparam logic [NUM_W-1:0]  ROUND_BIAS  = 11'd5;
   localparam logic [NUM_W-1:0]  WEIGHT_Y    = 11'd6;

   // Register map
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Control of the transaction sitting in the line store read stage
   typedef struct packed {
      logic valid;
      logic produce;
      logic last;
   } stage_ctl_type;

   // Gradient stage result handed to the magnitude stage
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic [ABS_W-1:0]         abs_x;
      logic [ABS_W-1:0]         abs_y;
   } grad_type;

   // Absolute value saturated to 255
   function automatic logic [ABS_W-1:0] sat_abs(input logic signed [GRAD_W-1:0] v);
      logic [GRAD_W-1:0] m;
      m = v[GRAD_W-1] ? GRAD_W'(-v) : GRAD_W'(v);
      return (m > GRAD_W'(255)) ? ABS_W'(255) : m[ABS_W-1:0];
   endfunction

endpackage

>>> hdl/sgm_line_store.sv
// Dual line store: one synchronous memory holding the upper and middle rows.
module sgm_line_store import sgm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [2*PIXEL_W-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [2*PIXEL_W-1:0] wr_data
);

   // Word layout: upper row in the high byte, middle row in the low byte
   logic [2*PIXEL_W-1:0] mem_ff [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sgm_window.sv
// 3x3 window registers and Sobel X/Y kernels, registered into the gradient stage.
module sgm_window import sgm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               advance,
   input  stage_ctl_type      s1_ctl,
   input  logic [PIXEL_W-1:0] cur_pixel,
   input  logic [PIXEL_W-1:0] up_pixel,
   input  logic [PIXEL_W-1:0] mid_pixel,
   output grad_type           s2
);

   // Two previous columns of each row: index 0 is col-2, index 1 is col-1
   logic [PIXEL_W-1:0] upper_ff [2];
   logic [PIXEL_W-1:0] middle_ff [2];
   logic [PIXEL_W-1:0] lower_ff [2];
   grad_type           s2_ff;

   logic signed [GRAD_W-1:0] tl, tc, tr, ml, mr, bl, bc, br;
   logic signed [GRAD_W-1:0] gx, gy;

   // Window taps widened to the gradient width
   assign tl = $signed(GRAD_W'(upper_ff[0]));
   assign tc = $signed(GRAD_W'(upper_ff[1]));
   assign tr = $signed(GRAD_W'(up_pixel));
   assign ml = $signed(GRAD_W'(middle_ff[0]));
   assign mr = $signed(GRAD_W'(mid_pixel));
   assign bl = $signed(GRAD_W'(lower_ff[0]));
   assign bc = $signed(GRAD_W'(lower_ff[1]));
   assign br = $signed(GRAD_W'(cur_pixel));

   // Sobel kernels
   assign gx = (tl - tr) + ((ml - mr) <<< 1) + (bl - br);
   assign gy = (tl + (tc <<< 1) + tr) - (bl + (bc <<< 1) + br);

   // Window shift as each transaction leaves the read stage
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         upper_ff[0]  <= '0;
         upper_ff[1]  <= '0;
         middle_ff[0] <= '0;
         middle_ff[1] <= '0;
         lower_ff[0]  <= '0;
         lower_ff[1]  <= '0;
      end else if (advance && s1_ctl.valid) begin
         upper_ff[0]  <= upper_ff[1];
         upper_ff[1]  <= up_pixel;
         middle_ff[0] <= middle_ff[1];
         middle_ff[1] <= mid_pixel;
         lower_ff[0]  <= lower_ff[1];
         lower_ff[1]  <= cur_pixel;
      end
   end

   // Gradient stage register; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff.valid <= s1_ctl.valid && s1_ctl.produce;
      end
      if (advance) begin
         s2_ff.last   <= s1_ctl.last;
         s2_ff.grad_x <= gx;
         s2_ff.grad_y <= gy;
         s2_ff.abs_x  <= sat_abs(gx);
         s2_ff.abs_y  <= sat_abs(gy);
      end
   end

   assign s2 = s2_ff;

endmodule

>>> hdl/sgm_magnitude.sv
// Weighted rounded magnitude and the result output register.
module sgm_magnitude import sgm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  grad_type                 s2,
   output logic                     rsp_valid,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_frame_last
);

   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;

   logic                     valid_ff;
   logic signed [GRAD_W-1:0] grad_x_ff;
   logic signed [GRAD_W-1:0] grad_y_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     last_ff;

   // 2a + 6b + 5, then divide by ten through the reciprocal
   assign num  = (NUM_W'(s2.abs_x) << 1) + (NUM_W'(s2.abs_y) * WEIGHT_Y) + ROUND_BIAS;
   assign prod = PROD_W'(num) * DIV10_RECIP;

   // Output register; a new transaction loads whenever the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s2.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         grad_x_ff <= s2.grad_x;
         grad_y_ff <= s2.grad_y;
         mag_ff    <= prod[DIV10_SHIFT +: MAG_W];
         last_ff   <= s2.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_grad_x     = grad_x_ff;
   assign rsp_grad_y     = grad_y_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_frame_last = last_ff;

endmodule

>>> hdl/sobel_gradient_magnitude.sv
// Sobel gradient magnitude: counters, register port and pipeline control.
// A pixel passes the read, gradient and output registers before reaching rsp.
// Throughput: one pixel per cycle; the line store takes one read and one write
// per cycle, so a stalled rsp channel is the only thing that holds the input.
// Reset: registers return to 640 x 480, counters and window clear; line store
// contents stay undefined and are always written before they feed a result.
module sobel_gradient_magnitude import sgm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // Pixel input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIXEL_W-1:0]       req_pixel,
   // Gradient result
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_frame_last,
   // Register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic                    cfg_write;
   reg_index_type           cfg_index;

   logic [CW-1:0]           width_ext;
   logic [AW-1:0]           width_last;
   logic [HEIGHT_REG_W-1:0] height_last;

   logic [AW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic                    advance;
   logic                    accept;

   stage_ctl_type           s1_ctl_ff;
   logic [PIXEL_W-1:0]      s1_pixel_ff;
   logic [AW-1:0]           s1_col_ff;

   logic [2*PIXEL_W-1:0]    rd_data;
   logic [PIXEL_W-1:0]      up_pixel;
   logic [PIXEL_W-1:0]      mid_pixel;
   grad_type                s2;

   // Register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[HEIGHT_REG_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   // Effective frame size: width clamped to [3, MAX_WIDTH], height at least 3
   assign width_ext = CW'(image_width_ff);

   always_comb begin
      priority if (width_ext < CW'(MIN_DIM)) begin
         width_last = AW'(MIN_DIM - 1);
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         width_last = AW'(MAX_WIDTH - 1);
      end else begin
         width_last = AW'(width_ext - CW'(1));
      end
   end

   assign height_last = (image_height_ff < HEIGHT_REG_W'(MIN_DIM)) ?
                        HEIGHT_REG_W'(MIN_DIM - 1) : image_height_ff - HEIGHT_REG_W'(1);

   // Whole pipeline moves together whenever the output register can take data
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Raster position of the next pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == width_last) begin
            col_in = '0;
            row_in = (row_ff == height_last) ? '0 : row_ff + HEIGHT_REG_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store read stage: the transaction waits here for the memory data
   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         s1_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ctl_ff.valid <= accept;
      end
      if (accept) begin
         s1_ctl_ff.produce <= (col_ff >= AW'(2)) && (row_ff >= HEIGHT_REG_W'(2));
         s1_ctl_ff.last    <= (col_ff == width_last) && (row_ff == height_last);
         s1_pixel_ff       <= req_pixel;
         s1_col_ff         <= col_ff;
      end
   end

   assign up_pixel  = rd_data[2*PIXEL_W-1:PIXEL_W];
   assign mid_pixel = rd_data[PIXEL_W-1:0];

   // Read at the accept edge, write back as the transaction leaves the read stage;
   // consecutive transactions never share an address since rows are 3 or wider
   sgm_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_ctl_ff.valid && advance),
      .wr_addr (s1_col_ff),
      .wr_data ({mid_pixel, s1_pixel_ff})
   );

   sgm_window u_window (
      .clock     (clock),
      .reset     (reset),
      .clear     (cfg_write),
      .advance   (advance),
      .s1_ctl    (s1_ctl_ff),
      .cur_pixel (s1_pixel_ff),
      .up_pixel  (up_pixel),
      .mid_pixel (mid_pixel),
      .s2        (s2)
   );

   sgm_magnitude u_magnitude (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s2             (s2),
      .rsp_valid      (rsp_valid),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> verif/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Sobel gradient magnitude block.
module testbench import sgm_pkg::*; ();

   localparam int LATENCY       = 3;
   localparam int SETTLE_CYCLES = LATENCY + 2;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1150;

   // 3x3 test frames, raster order, first pixel in the top byte
   localparam logic [71:0] EDGE_VERTICAL   = {8'd255, 8'd128, 8'd0,
                                              8'd255, 8'd128, 8'd0,
                                              8'd255, 8'd128, 8'd0};
   localparam logic [71:0] EDGE_HORIZONTAL = {8'd255, 8'd255, 8'd255,
                                              8'd17,  8'd17,  8'd17,
                                              8'd0,   8'd0,   8'd0};
   localparam logic [71:0] CORNER_BRIGHT   = {8'd255, 8'd255, 8'd0,
                                              8'd255, 8'd0,   8'd0,
                                              8'd0,   8'd0,   8'd0};

   typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pixel_style_type;

   typedef struct {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic [MAG_W-1:0]         magnitude;
      logic                     frame_last;
   } gradient_type;

   // Gradient predictor and queue of pending gradient results
   class sobel_scoreboard;
      logic [PIXEL_W-1:0]      upper_line [MAX_WIDTH_DEFAULT];
      logic [PIXEL_W-1:0]      middle_line [MAX_WIDTH_DEFAULT];
      logic [PIXEL_W-1:0]      upper_win [2];
      logic [PIXEL_W-1:0]      middle_win [2];
      logic [PIXEL_W-1:0]      lower_win [2];
      int                      col;
      int                      row;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      gradient_type            expected_q [$];
      int                      errors;
      int                      checked;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         width_reg  = IMAGE_WIDTH_RESET;
         height_reg = IMAGE_HEIGHT_RESET;
         errors     = 0;
         checked    = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         col = 0;
         row = 0;
         for (int k = 0; k < 2; k++) begin
            upper_win[k]  = '0;
            middle_win[k] = '0;
            lower_win[k]  = '0;
         end
      endfunction

      // Any register write restarts the frame; line stores keep their data
      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_reg = data[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_reg = data[HEIGHT_REG_W-1:0];
            end
         endcase
         restart_frame();
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(reg_index_type idx);
         return (idx == REG_IMAGE_WIDTH) ? CSR_DATA_W'(width_reg) : CSR_DATA_W'(height_reg);
      endfunction

      // Out of range sizes are clamped
      function int eff_width();
         int w;
         w = int'(width_reg);
         if (w < MIN_DIM) w = MIN_DIM;
         else if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
         return w;
      endfunction

      function int eff_height();
         int h;
         h = int'(height_reg);
         if (h < MIN_DIM) h = MIN_DIM;
         return h;
      endfunction

      function int clip_abs(int v);
         int m;
         m = (v < 0) ? -v : v;
         return (m > 255) ? 255 : m;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Accepted pixel: predict the result for the interior pixel up-left of it
      function void note_pixel(logic [PIXEL_W-1:0] cur);
         int           w, h, gx, gy, a, b;
         int           up, mid, px;
         gradient_type res;
         w   = eff_width();
         h   = eff_height();
         up  = int'(upper_line[col]);
         mid = int'(middle_line[col]);
         px  = int'(cur);
         if (col >= 2 && row >= 2) begin
            gx = (int'(upper_win[0]) - up) + 2 * (int'(middle_win[0]) - mid)
                 + (int'(lower_win[0]) - px);
            gy = (int'(upper_win[0]) + 2 * int'(upper_win[1]) + up)
                 - (int'(lower_win[0]) + 2 * int'(lower_win[1]) + px);
            a  = clip_abs(gx);
            b  = clip_abs(gy);
            res.grad_x     = GRAD_W'(gx);
            res.grad_y     = GRAD_W'(gy);
            res.magnitude  = MAG_W'((2 * a + 6 * b + 5) / 10);
            res.frame_last = (col == w - 1) && (row == h - 1);
            expected_q.push_back(res);
         end
         // shift window columns
         upper_win[0]  = upper_win[1];
         upper_win[1]  = PIXEL_W'(up);
         middle_win[0] = middle_win[1];
         middle_win[1] = PIXEL_W'(mid);
         lower_win[0]  = lower_win[1];
         lower_win[1]  = cur;
         // roll line stores
         upper_line[col]  = PIXEL_W'(mid);
         middle_line[col] = cur;
         // raster counters
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR: %s", msg);
      endtask

      task check_result(input logic signed [GRAD_W-1:0] gx, input logic signed [GRAD_W-1:0] gy,
                        input logic [MAG_W-1:0] mag, input logic last);
         gradient_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with none pending: gx %0d gy %0d mag %0d", gx, gy, mag));
            return;
         end
         want = expected_q.pop_front();
         if (gx !== want.grad_x)
            report($sformatf("result %0d grad_x %0d, want %0d", checked, gx, want.grad_x));
         if (gy !== want.grad_y)
            report($sformatf("result %0d grad_y %0d, want %0d", checked, gy, want.grad_y));
         if (mag !== want.magnitude)
            report($sformatf("result %0d magnitude %0d, want %0d", checked, mag,
                             want.magnitude));
         if (last !== want.frame_last)
            report($sformatf("result %0d frame_last %b, want %b", checked, last,
                             want.frame_last));
         checked++;
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIXEL_W-1:0]       req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic [MAG_W-1:0]         rsp_magnitude;
   logic                     rsp_frame_last;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [CSR_DATA_W-1:0]    pwdata = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   sobel_scoreboard sb = new();
   int              req_burst = 0;
   int              rsp_burst = 0;
   int              pixels_sent = 0;
   int              cycle_count = 0;

   sobel_gradient_magnitude dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Monitor: note accepted pixels, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pixel(req_pixel);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_grad_x, rsp_grad_y, rsp_magnitude, rsp_frame_last);
      end
   end

   // Idle gap per transaction, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // Result side stalls
   initial begin : rsp_stall
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   function automatic logic [PIXEL_W-1:0] next_pixel(pixel_style_type style, inout int level);
      case (style)
         PIX_EXTREME: begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         PIX_SMOOTH: begin
            level = level + int'($urandom_range(0, 6)) - 3;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            return PIXEL_W'(level);
         end
         default: begin
            return PIXEL_W'($urandom());
         end
      endcase
   endfunction

   // Valid stays high across back-to-back pixels
   task automatic send_pixel(input logic [PIXEL_W-1:0] p);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_stream(input int count, input pixel_style_type style);
      int level;
      level = $urandom_range(0, 255);
      for (int k = 0; k < count; k++) begin
         // sender hold-off until the block has caught up
         if (pixels_sent % 400 == 200) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         send_pixel(next_pixel(style, level));
      end
   endtask

   task automatic send_pattern(input logic [71:0] pattern);
      for (int k = 0; k < 9; k++) send_pixel(pattern[71 - 8 * k -: 8]);
   endtask

   // One APB transfer; back-to-back transfers skip the idle state
   task automatic csr_cycle(input logic is_write, input reg_index_type idx,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
   endtask

   task automatic verify_reg(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] rdata;
      csr_cycle(1'b0, idx, '0, rdata);
      if (rdata !== sb.reg_value(idx))
         sb.report($sformatf("register %s reads %0d, want %0d", idx.name(), rdata,
                             sb.reg_value(idx)));
   endtask

   // Write, sometimes with random junk above the register width, then read back
   task automatic program_reg(input reg_index_type idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] mask, data, rdata;
      mask = (idx == REG_IMAGE_WIDTH) ? CSR_DATA_W'((1 << WIDTH_REG_W) - 1)
                                      : CSR_DATA_W'((1 << HEIGHT_REG_W) - 1);
      data = CSR_DATA_W'(value) & mask;
      if ($urandom_range(0, 1)) data = data | (CSR_DATA_W'($urandom()) & ~mask);
      csr_cycle(1'b1, idx, data, rdata);
      sb.write_reg(idx, data);
      verify_reg(idx);
   endtask

   task automatic set_frame_size(input int unsigned w, input int unsigned h);
      program_reg(REG_IMAGE_WIDTH, w);
      program_reg(REG_IMAGE_HEIGHT, h);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int              start, w, h, frames, tail, fsize;
      pixel_style_type style;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the size registers
      verify_reg(REG_IMAGE_WIDTH);
      verify_reg(REG_IMAGE_HEIGHT);

      // directed: full scale gradients, two frames back to back
      set_frame_size(3, 3);
      send_pattern(EDGE_VERTICAL);
      send_pattern(EDGE_HORIZONTAL);
      // sizes below the minimum, both gradients saturated
      req_valid <= 1'b0;
      wait_drained();
      set_frame_size(1, 2);
      send_pattern(CORNER_BRIGHT);

      // random frames of small sizes, often ending mid-frame
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
         h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
         case ($urandom_range(0, 3))
            0:       style = PIX_EXTREME;
            1:       style = PIX_SMOOTH;
            default: style = PIX_UNIFORM;
         endcase
         req_valid <= 1'b0;
         wait_drained();
         set_frame_size(w, h);
         fsize  = sb.eff_width() * sb.eff_height();
         frames = $urandom_range(1, 3);
         tail   = $urandom_range(0, 1) ? $urandom_range(1, fsize - 1) : 0;
         send_stream(frames * fsize + tail, style);
      end

      // width beyond the maximum clamps; top row only, so no results may appear
      req_valid <= 1'b0;
      wait_drained();
      set_frame_size(2047, 3);
      send_stream(MAX_WIDTH_DEFAULT / 8, PIX_UNIFORM);

      req_valid <= 1'b0;
      wait_drained();
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sgm_pkg.sv
hdl/sgm_line_store.sv
hdl/sgm_window.sv
hdl/sgm_magnitude.sv
hdl/sobel_gradient_magnitude.sv
verif/sobel_gradient_magnitude_tb.sv
